### src/spi_pkg.sv
`timescale 1ns / 1ps
package spi_pkg;

    localparam int SpiDepth = 64;
    localparam int CoordW   = 16;
    localparam int DistW    = 32;
    localparam int PosW     = 7;
    localparam int ModeW    = 2;

    typedef enum logic [ModeW-1:0] {
        MODE_XY   = 2'd0,
        MODE_YX   = 2'd1,
        MODE_DIST = 2'd2
    } sort_mode_t;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_DRAIN  = 1'b1;

    // A stored point together with its squared distance from the origin.
    typedef struct packed {
        logic signed [CoordW-1:0] x;
        logic signed [CoordW-1:0] y;
        logic        [DistW-1:0]  dist_sq;
    } spi_point_t;

    // Per-cell control from the row controller.
    typedef struct packed {
        logic ins;
        logic drain;
        logic keep_self;
        logic keep_left;
    } spi_cell_ctl_t;

endpackage

### src/spi_item.sv
`timescale 1ns / 1ps
module spi_item
    import spi_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic                     func,
    input  logic signed [CoordW-1:0] point_x,
    input  logic signed [CoordW-1:0] point_y,
    input  logic                     take,
    output logic                     in_stall,
    output logic                     item_valid,
    output logic                     item_func,
    output spi_point_t               item_pt
);

    logic                     valid_reg;
    logic                     valid_next;
    logic                     func_reg;
    spi_point_t               pt_reg;
    spi_point_t               pt_next;
    logic signed [DistW-1:0]  xx;
    logic signed [DistW-1:0]  yy;
    logic                     load;

    assign in_stall = valid_reg && !take;
    assign load     = in_valid && !in_stall;

    // Both squares are nonnegative, so their sum fits the unsigned width.
    assign xx = DistW'(point_x) * DistW'(point_x);
    assign yy = DistW'(point_y) * DistW'(point_y);

    always_comb
    begin
        pt_next.x       = point_x;
        pt_next.y       = point_y;
        pt_next.dist_sq = $unsigned(xx) + $unsigned(yy);
    end

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            func_reg <= func;
            pt_reg   <= pt_next;
        end
    end

    assign item_valid = valid_reg;
    assign item_func  = func_reg;
    assign item_pt    = pt_reg;

endmodule

### src/spi_cell.sv
`timescale 1ns / 1ps
module spi_cell
    import spi_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [ModeW-1:0] sort_mode,
    input  spi_cell_ctl_t    ctl,
    input  spi_point_t       new_pt,
    input  spi_point_t       left_pt,
    input  logic             left_valid,
    input  spi_point_t       right_pt,
    input  logic             right_valid,
    output spi_point_t       pt,
    output logic             valid,
    output logic             ge
);

    spi_point_t pt_reg;
    spi_point_t pt_next;
    logic       valid_reg;
    logic       valid_next;

    // True when point a sorts strictly before point b.
    function automatic logic pt_less(spi_point_t a, spi_point_t b, logic [ModeW-1:0] mode);
        logic x_lt;
        logic x_eq;
        logic y_lt;
        logic y_eq;
        logic d_lt;
        logic d_eq;
        logic r;
        x_lt = a.x < b.x;
        x_eq = a.x == b.x;
        y_lt = a.y < b.y;
        y_eq = a.y == b.y;
        d_lt = a.dist_sq < b.dist_sq;
        d_eq = a.dist_sq == b.dist_sq;
        case (mode)
            MODE_YX:   r = y_lt | (y_eq & x_lt);
            MODE_DIST: r = d_lt | (d_eq & (x_lt | (x_eq & y_lt)));
            default:   r = x_lt | (x_eq & y_lt);
        endcase
        return r;
    endfunction

    assign ge = valid_reg && !pt_less(new_pt, pt_reg, sort_mode);

    always_comb
    begin
        pt_next    = pt_reg;
        valid_next = valid_reg;
        if (ctl.drain)
        begin
            pt_next    = right_pt;
            valid_next = right_valid;
        end
        else if (ctl.ins && !ctl.keep_self)
        begin
            if (ctl.keep_left)
            begin
                pt_next    = new_pt;
                valid_next = 1'b1;
            end
            else
            begin
                pt_next    = left_pt;
                valid_next = left_valid;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pt_reg <= pt_next;
    end

    assign pt    = pt_reg;
    assign valid = valid_reg;

endmodule

### src/sorted_point_insert_core.sv
`timescale 1ns / 1ps
// A request is registered on acceptance; its result is registered in the output register.
// Throughput, while the output does not stall: one insert request per cycle; a drain sends
// out the stored points in order, the row shifting one place toward the output each cycle.
// Reset clears the cell valid bits, the pending request, the output and sets sort mode 0;
// the stored coordinates themselves are not cleared.
module sorted_point_insert_core
    import spi_pkg::*;
#(
    parameter int DEPTH = SpiDepth
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [ModeW-1:0]         cfg_wdata,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     func,
    input  logic signed [CoordW-1:0] point_x,
    input  logic signed [CoordW-1:0] point_y,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [CoordW-1:0] out_x,
    output logic signed [CoordW-1:0] out_y,
    output logic [PosW-1:0]          position,
    output logic                     dropped,
    output logic                     last
);

    // Sort mode register; an unused code compares like x-then-y.
    logic [ModeW-1:0] sort_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sort_mode_reg <= MODE_XY;
        end
        else if (cfg_we)
        begin
            sort_mode_reg <= cfg_wdata;
        end
    end

    // The request under work. It stays here until the row has finished with it: an insert
    // until its result is sent, a drain until its last entry is sent or the row is empty.
    logic       item_valid;
    logic       item_func;
    spi_point_t item_pt;
    logic       take;

    spi_item u_item (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .func       (func),
        .point_x    (point_x),
        .point_y    (point_y),
        .take       (take),
        .in_stall   (in_stall),
        .item_valid (item_valid),
        .item_func  (item_func),
        .item_pt    (item_pt)
    );

    // The cell row. Cell 0 holds the smallest point; valid cells form a prefix.
    spi_point_t       cell_pt [DEPTH];
    logic [DEPTH-1:0] cell_valid;
    logic [DEPTH-1:0] ge;
    logic [DEPTH-1:0] keep;
    logic [DEPTH-1:0] keep_up;
    logic [DEPTH-1:0] keep_left;
    spi_cell_ctl_t    ctl [DEPTH];
    logic             ins_shift;
    logic             drain_shift;

    // A cell keeps its point when it, or any cell above it, holds a point that
    // the new point does not sort before. The new point lands at the first cell
    // that is not kept, and everything from there on moves up one place.
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            keep[i] = |(ge >> i);
        end
    end

    assign keep_up   = {1'b0, keep[DEPTH-1:1]};
    assign keep_left = {keep[DEPTH-2:0], 1'b1};

    generate
        for (genvar g = 0; g < DEPTH; g++)
        begin : g_cell
            spi_point_t left_pt;
            logic       left_valid;
            spi_point_t right_pt;
            logic       right_valid;

            if (g == 0)
            begin : g_first
                assign left_pt    = item_pt;
                assign left_valid = 1'b0;
            end
            else
            begin : g_inner_left
                assign left_pt    = cell_pt[g-1];
                assign left_valid = cell_valid[g-1];
            end

            if (g == DEPTH - 1)
            begin : g_final
                assign right_pt    = item_pt;
                assign right_valid = 1'b0;
            end
            else
            begin : g_inner_right
                assign right_pt    = cell_pt[g+1];
                assign right_valid = cell_valid[g+1];
            end

            always_comb
            begin
                ctl[g].ins       = ins_shift;
                ctl[g].drain     = drain_shift;
                ctl[g].keep_self = keep[g];
                ctl[g].keep_left = keep_left[g];
            end

            spi_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .sort_mode   (sort_mode_reg),
                .ctl         (ctl[g]),
                .new_pt      (item_pt),
                .left_pt     (left_pt),
                .left_valid  (left_valid),
                .right_pt    (right_pt),
                .right_valid (right_valid),
                .pt          (cell_pt[g]),
                .valid       (cell_valid[g]),
                .ge          (ge[g])
            );
        end
    endgenerate

    // Insert position: the kept cells form a prefix, so its boundary is one-hot.
    logic [PosW-1:0] ins_pos;

    always_comb
    begin
        ins_pos = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (keep[i] && !keep_up[i])
            begin
                ins_pos = ins_pos | PosW'(i + 1);
            end
        end
    end

    // Request control. A result is produced only when the output register is
    // free or is being emptied in the same cycle.
    logic            out_valid_reg;
    logic            out_valid_next;
    logic            out_free;
    logic            full;
    logic            empty;
    logic            is_ins;
    logic            is_drain;
    logic            ins_go;
    logic            drain_go;
    logic            drain_skip;
    logic            drain_end;
    logic            emit;
    logic [PosW-1:0] drain_pos_reg;
    logic [PosW-1:0] drain_pos_next;

    assign out_free   = !out_valid_reg || !out_stall;
    assign full       = cell_valid[DEPTH-1];
    assign empty      = !cell_valid[0];
    assign is_ins     = item_valid && (item_func == FUNC_INSERT);
    assign is_drain   = item_valid && (item_func == FUNC_DRAIN);
    assign ins_go     = is_ins && out_free;
    assign drain_go   = is_drain && !empty && out_free;
    assign drain_skip = is_drain && empty;
    assign drain_end  = drain_go && !cell_valid[1];
    assign emit       = ins_go || drain_go;
    assign take       = ins_go || drain_skip || drain_end;

    // A full table refuses the point and leaves the row untouched.
    assign ins_shift   = ins_go && !full;
    assign drain_shift = drain_go;

    always_comb
    begin
        drain_pos_next = drain_pos_reg;
        if (drain_go)
        begin
            if (drain_end)
            begin
                drain_pos_next = '0;
            end
            else
            begin
                drain_pos_next = drain_pos_reg + PosW'(1);
            end
        end
    end

    always_comb
    begin
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            drain_pos_reg <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            drain_pos_reg <= drain_pos_next;
        end
    end

    // Output payload. A drain sends out the bottom cell while the row shifts down.
    logic signed [CoordW-1:0] out_x_reg;
    logic signed [CoordW-1:0] out_y_reg;
    logic [PosW-1:0]          position_reg;
    logic                     dropped_reg;
    logic                     last_reg;

    always_ff @(posedge clk)
    begin
        if (ins_go)
        begin
            out_x_reg    <= item_pt.x;
            out_y_reg    <= item_pt.y;
            position_reg <= full ? PosW'(DEPTH) : ins_pos;
            dropped_reg  <= full;
            last_reg     <= 1'b1;
        end
        else if (drain_go)
        begin
            out_x_reg    <= cell_pt[0].x;
            out_y_reg    <= cell_pt[0].y;
            position_reg <= drain_pos_reg;
            dropped_reg  <= 1'b0;
            last_reg     <= !cell_valid[1];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign position  = position_reg;
    assign dropped   = dropped_reg;
    assign last      = last_reg;

endmodule
